### rtl/seqlog_pkg.sv
// Shared types and constants of the sequenced event log ring.
// No dependencies; seqlog_ctrl, seqlog_dp and the top level refer to it by scoped names.
package seqlog_pkg;

   // Payload lanes on the ports (bytes 0..7 low word, 8..11 high word)
   localparam int unsigned PAYLOAD_LANES = 12;
   localparam int unsigned PAYLOAD_W     = 8 * PAYLOAD_LANES;
   localparam int unsigned REC_LEN_W     = 4;
   localparam int unsigned COUNT_W       = 6;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_REPLY
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request payload
      logic execute;   // apply the operation to stores and counters
   } ctrl_cmd_type;

   // One slot of the record store
   typedef struct packed {
      logic [31:0]          seq_num;
      logic [31:0]          time_ms;
      logic [15:0]          source;
      logic [15:0]          evt;
      logic [7:0]           severity;
      logic [REC_LEN_W-1:0] length;
   } rec_type;

endpackage

### rtl/seqlog_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Widths follow the port layout of the sequenced event log ring.
interface seqlog_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  severity;
   logic [15:0] source_id;
   logic [15:0] event_code;
   logic [31:0] time_ms;
   logic [7:0]  length;
   logic        payload_present;
   logic [63:0] payload_low;
   logic [31:0] payload_high;
   logic [4:0]  read_index;

   modport source (output valid, mode, severity, source_id, event_code, time_ms, length,
                   payload_present, payload_low, payload_high, read_index,
                   input ready);
   modport sink (input valid, mode, severity, source_id, event_code, time_ms, length,
                 payload_present, payload_low, payload_high, read_index,
                 output ready);
endinterface

interface seqlog_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_valid;
   logic [31:0] rec_sequence;
   logic [31:0] rec_time_ms;
   logic [15:0] rec_source;
   logic [15:0] rec_event;
   logic [7:0]  rec_severity;
   logic [3:0]  rec_length;
   logic [63:0] rec_payload_low;
   logic [31:0] rec_payload_high;
   logic [5:0]  record_count;
   logic [31:0] dropped_count;
   logic [31:0] last_sequence;

   modport source (output valid, record_valid, rec_sequence, rec_time_ms, rec_source,
                   rec_event, rec_severity, rec_length, rec_payload_low,
                   rec_payload_high, record_count, dropped_count, last_sequence,
                   input ready);
   modport sink (input valid, record_valid, rec_sequence, rec_time_ms, rec_source,
                 rec_event, rec_severity, rec_length, rec_payload_low,
                 rec_payload_high, record_count, dropped_count, last_sequence,
                 output ready);
endinterface

### rtl/seqlog_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module seqlog_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/seqlog_ctrl.sv
// Transaction sequencer of the event log: accept, access, reply.
// Depends on seqlog_pkg (state_type, ctrl_cmd_type).
module seqlog_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output seqlog_pkg::ctrl_cmd_type  cmd
);

   seqlog_pkg::state_type state_ff;
   seqlog_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= seqlog_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         seqlog_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = seqlog_pkg::ST_ACCESS;
            end
         end
         seqlog_pkg::ST_ACCESS: begin
            cmd.execute = 1'b1;
            state_in    = seqlog_pkg::ST_REPLY;
         end
         seqlog_pkg::ST_REPLY: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = seqlog_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = seqlog_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/seqlog_dp.sv
// Datapath of the event log: request latch, counters, record and payload stores.
// Depends on seqlog_pkg and seqlog_ram.
module seqlog_dp #(
   parameter int unsigned CAPACITY      = 32,
   parameter int unsigned PAYLOAD_BYTES = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  seqlog_pkg::ctrl_cmd_type cmd,
   // request payload
   input  logic [1:0]               req_mode,
   input  logic [7:0]               req_severity,
   input  logic [15:0]              req_source,
   input  logic [15:0]              req_event_code,
   input  logic [31:0]              req_time_ms,
   input  logic [7:0]               req_length,
   input  logic                     req_payload_present,
   input  logic [63:0]              req_payload_low,
   input  logic [31:0]              req_payload_high,
   input  logic [4:0]               req_read_index,
   // response payload
   output logic                     rsp_record_valid,
   output logic [31:0]              rsp_rec_sequence,
   output logic [31:0]              rsp_rec_time_ms,
   output logic [15:0]              rsp_rec_source,
   output logic [15:0]              rsp_rec_event,
   output logic [7:0]               rsp_rec_severity,
   output logic [3:0]               rsp_rec_length,
   output logic [63:0]              rsp_rec_payload_low,
   output logic [31:0]              rsp_rec_payload_high,
   output logic [5:0]               rsp_record_count,
   output logic [31:0]              rsp_dropped_count,
   output logic [31:0]              rsp_last_sequence
);

   localparam int unsigned SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned HELD_W = $clog2(CAPACITY + 1);
   localparam int unsigned POS_W  = SLOT_W + 1;
   localparam int unsigned CMP_W  = (HELD_W > 5) ? HELD_W : 5;
   localparam int unsigned REC_W  = $bits(seqlog_pkg::rec_type);
   localparam int unsigned LEN_W  = seqlog_pkg::REC_LEN_W;

   // latched request
   seqlog_pkg::mode_type mode_ff;
   logic [7:0]           severity_ff;
   logic [15:0]          source_ff;
   logic [15:0]          event_ff;
   logic [31:0]          time_ff;
   logic [7:0]           length_ff;
   logic                 present_ff;
   logic [seqlog_pkg::PAYLOAD_W-1:0] payload_ff;
   logic [4:0]           index_ff;

   // control state
   logic [31:0]       next_seq_ff, next_seq_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [31:0]       drop_ff, drop_in;
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   logic              rec_valid_ff, rec_valid_in;

   logic              exhausted;
   logic              full;
   logic              is_write, is_read;
   logic              over_len;
   logic [LEN_W-1:0]  len_clamped;
   logic              store_en;
   logic [1:0]        drop_inc;
   logic [32:0]       drop_sum;
   logic              index_hit;
   logic [POS_W-1:0]  base_pos, oldest_pos, read_pos;
   logic [SLOT_W-1:0] rd_slot;

   seqlog_pkg::rec_type wr_rec, rd_rec;
   logic [REC_W-1:0]    rd_rec_bits;
   logic [seqlog_pkg::PAYLOAD_W-1:0] rec_bytes;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= seqlog_pkg::mode_type'(req_mode);
         severity_ff <= req_severity;
         source_ff   <= req_source;
         event_ff    <= req_event_code;
         time_ff     <= req_time_ms;
         length_ff   <= req_length;
         present_ff  <= req_payload_present;
         payload_ff  <= {req_payload_high, req_payload_low};
         index_ff    <= req_read_index;
      end
   end

   assign exhausted = (next_seq_ff == 32'd0);
   assign full      = (held_ff == HELD_W'(CAPACITY));
   assign is_write  = cmd.execute && (mode_ff == seqlog_pkg::MODE_WRITE);
   assign is_read   = cmd.execute && (mode_ff == seqlog_pkg::MODE_READ);
   assign over_len  = (length_ff > 8'(PAYLOAD_BYTES));
   assign len_clamped = over_len ? LEN_W'(PAYLOAD_BYTES) : length_ff[LEN_W-1:0];
   assign store_en  = is_write && !exhausted;
   assign index_hit = (CMP_W'(index_ff) < CMP_W'(held_ff));

   // oldest slot = write slot - held (mod CAPACITY), then step forward by the index
   always_comb begin
      base_pos   = POS_W'(wr_slot_ff) + POS_W'(CAPACITY) - POS_W'(held_ff);
      oldest_pos = (base_pos >= POS_W'(CAPACITY)) ? base_pos - POS_W'(CAPACITY) : base_pos;
      read_pos   = oldest_pos + POS_W'(index_ff);
      if (read_pos >= POS_W'(CAPACITY)) begin
         read_pos = read_pos - POS_W'(CAPACITY);
      end
   end
   assign rd_slot = read_pos[SLOT_W-1:0];

   always_comb begin
      next_seq_in  = next_seq_ff;
      held_in      = held_ff;
      wr_slot_in   = wr_slot_ff;
      rec_valid_in = rec_valid_ff;
      drop_inc     = 2'd0;
      if (cmd.execute) begin
         rec_valid_in = is_read && index_hit;
      end
      if (is_write) begin
         if (exhausted) begin
            drop_inc = 2'd1;
         end else begin
            drop_inc    = 2'(over_len) + 2'(full);
            next_seq_in = next_seq_ff + 32'd1;
            wr_slot_in  = (wr_slot_ff == SLOT_W'(CAPACITY - 1)) ? '0 : wr_slot_ff + 1'b1;
            if (!full) begin
               held_in = held_ff + 1'b1;
            end
         end
      end
      // saturate the drop counter at all ones
      drop_sum = {1'b0, drop_ff} + 33'(drop_inc);
      drop_in  = drop_sum[32] ? '1 : drop_sum[31:0];
      if (cmd.execute && (mode_ff == seqlog_pkg::MODE_CLEAR)) begin
         held_in = '0;
         drop_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_seq_ff  <= 32'd1;
         held_ff      <= '0;
         drop_ff      <= '0;
         wr_slot_ff   <= '0;
         rec_valid_ff <= 1'b0;
      end else begin
         next_seq_ff  <= next_seq_in;
         held_ff      <= held_in;
         drop_ff      <= drop_in;
         wr_slot_ff   <= wr_slot_in;
         rec_valid_ff <= rec_valid_in;
      end
   end

   // record store
   always_comb begin
      wr_rec.seq_num  = next_seq_ff;
      wr_rec.time_ms  = time_ff;
      wr_rec.source   = source_ff;
      wr_rec.evt      = event_ff;
      wr_rec.severity = severity_ff;
      wr_rec.length   = len_clamped;
   end

   seqlog_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (wr_slot_ff),
      .wr_data (wr_rec),
      .rd_en   (is_read),
      .rd_addr (rd_slot),
      .rd_data (rd_rec_bits)
   );

   assign rd_rec = seqlog_pkg::rec_type'(rd_rec_bits);

   // one byte-wide store per used payload lane (below PAYLOAD_BYTES), so untouched bytes keep their contents
   for (genvar b = 0; b < seqlog_pkg::PAYLOAD_LANES; b++) begin : g_lane
      if (b < PAYLOAD_BYTES) begin : g_used
         logic       lane_wr;
         logic [7:0] lane_rd;

         assign lane_wr = store_en && present_ff && (LEN_W'(b) < len_clamped);

         seqlog_ram #(
            .WIDTH (8),
            .DEPTH (CAPACITY)
         ) u_pay_ram (
            .clock   (clock),
            .wr_en   (lane_wr),
            .wr_addr (wr_slot_ff),
            .wr_data (payload_ff[8*b +: 8]),
            .rd_en   (is_read),
            .rd_addr (rd_slot),
            .rd_data (lane_rd)
         );

         // zero the bytes at or past the stored length, and all bytes when no record is valid
         assign rec_bytes[8*b +: 8] =
            (rec_valid_ff && (LEN_W'(b) < rd_rec.length)) ? lane_rd : 8'd0;
      end else begin : g_unused
         assign rec_bytes[8*b +: 8] = 8'd0;
      end
   end

   assign rsp_record_valid     = rec_valid_ff;
   assign rsp_rec_sequence     = rec_valid_ff ? rd_rec.seq_num  : '0;
   assign rsp_rec_time_ms      = rec_valid_ff ? rd_rec.time_ms  : '0;
   assign rsp_rec_source       = rec_valid_ff ? rd_rec.source   : '0;
   assign rsp_rec_event        = rec_valid_ff ? rd_rec.evt      : '0;
   assign rsp_rec_severity     = rec_valid_ff ? rd_rec.severity : '0;
   assign rsp_rec_length       = rec_valid_ff ? rd_rec.length   : '0;
   assign rsp_rec_payload_low  = rec_bytes[63:0];
   assign rsp_rec_payload_high = rec_bytes[95:64];
   assign rsp_record_count     = seqlog_pkg::COUNT_W'(held_ff);
   assign rsp_dropped_count    = drop_ff;
   assign rsp_last_sequence    = exhausted ? '1 : next_seq_ff - 32'd1;

endmodule

### rtl/sequenced_event_log_ring.sv
// Top level of the sequenced event log ring: controller plus datapath.
// Depends on seqlog_pkg, seqlog_if, seqlog_ram, seqlog_ctrl, seqlog_dp.
//
//   channel   | dir | handshake     | carries
//   ----------+-----+---------------+------------------------------------------
//   req_chan  | in  | valid / ready | mode, record fields, payload, read index
//   rsp_chan  | out | valid / ready | read record, count, drops, last sequence
//
// A transaction accepted at one edge spends the next cycle in the store access
// (the record and payload RAMs have a single registered read port); the response
// is then valid in the reply state and holds until it is taken. The next request
// can be accepted in the cycle after the response is taken, so a transaction
// passes through accept, access and reply.
// Reset is synchronous: sequence returns to one, count and drops to zero.
// The stores hold no reset value and need no clearing pass after reset.
module sequenced_event_log_ring #(
   parameter int unsigned CAPACITY      = 32,
   parameter int unsigned PAYLOAD_BYTES = 12
) (
   input  logic          clock,
   input  logic          reset,
   seqlog_req_if.sink    req_chan,
   seqlog_rsp_if.source  rsp_chan
);

   seqlog_pkg::ctrl_cmd_type cmd;

   // sequence the transaction: accept, access, reply
   seqlog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // hold the latched request, counters and stores; drive the response fields
   seqlog_dp #(
      .CAPACITY      (CAPACITY),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_mode             (req_chan.mode),
      .req_severity         (req_chan.severity),
      .req_source           (req_chan.source_id),
      .req_event_code       (req_chan.event_code),
      .req_time_ms          (req_chan.time_ms),
      .req_length           (req_chan.length),
      .req_payload_present  (req_chan.payload_present),
      .req_payload_low      (req_chan.payload_low),
      .req_payload_high     (req_chan.payload_high),
      .req_read_index       (req_chan.read_index),
      .rsp_record_valid     (rsp_chan.record_valid),
      .rsp_rec_sequence     (rsp_chan.rec_sequence),
      .rsp_rec_time_ms      (rsp_chan.rec_time_ms),
      .rsp_rec_source       (rsp_chan.rec_source),
      .rsp_rec_event        (rsp_chan.rec_event),
      .rsp_rec_severity     (rsp_chan.rec_severity),
      .rsp_rec_length       (rsp_chan.rec_length),
      .rsp_rec_payload_low  (rsp_chan.rec_payload_low),
      .rsp_rec_payload_high (rsp_chan.rec_payload_high),
      .rsp_record_count     (rsp_chan.record_count),
      .rsp_dropped_count    (rsp_chan.dropped_count),
      .rsp_last_sequence    (rsp_chan.last_sequence)
   );

endmodule
